// ===== src/pcpt_pkg.sv =====
// pcpt_pkg: shared types, codes and helpers for the perceptron classify/train core
// holds the request and response transaction structs and the weight vector types
// no dependencies
`default_nettype none

package pcpt_pkg;

	// weight count and how many of them have a feature behind them
	localparam int NUM_WEIGHTS  = 4;
	localparam int NUM_FEATURES = 4;

	// field widths
	localparam int FEAT_W = 16;
	localparam int WGT_W  = 32;
	localparam int LR_W   = 16;

	// dot product widths: one product, then the sum over all weights
	localparam int PROD_W = FEAT_W + WGT_W;
	localparam int SUM_W  = PROD_W + $clog2(NUM_WEIGHTS) + 1;

	// function selector codes (the unused code behaves as classify)
	localparam logic [1:0] FUNC_CLASSIFY = 2'd0;
	localparam logic [1:0] FUNC_TRAIN    = 2'd1;
	localparam logic [1:0] FUNC_LOAD     = 2'd2;

	// learning rate after reset, Q0.16
	localparam logic [LR_W-1:0] LR_RESET = 16'd655;

	typedef logic signed [FEAT_W-1:0] feat_t;
	typedef logic signed [WGT_W-1:0]  wgt_t;
	typedef feat_t feat_vec_t [NUM_WEIGHTS];
	typedef wgt_t  wgt_vec_t  [NUM_WEIGHTS];

	// input transaction
	typedef struct packed {
		logic [1:0]               func;
		logic                     target;
		logic signed [FEAT_W-1:0] feature_0;
		logic signed [FEAT_W-1:0] feature_1;
		logic signed [FEAT_W-1:0] feature_2;
		logic signed [FEAT_W-1:0] feature_3;
	} req_t;

	// result transaction
	typedef struct packed {
		logic decision;
		logic mispredicted;
		logic saturated;
	} rsp_t;

	// weight update command from the control stage to the weight bank
	typedef struct packed {
		logic commit;
		logic train;
		logic load;
		logic target;
	} upd_cmd_t;

	// spread the feature fields over the weight lanes, zero past the last feature
	function automatic feat_vec_t feat_vec(req_t r);
		feat_vec_t v;
		for (int i = 0; i < NUM_WEIGHTS; i++) begin
			unique case (i)
				0:       v[i] = r.feature_0;
				1:       v[i] = r.feature_1;
				2:       v[i] = r.feature_2;
				3:       v[i] = r.feature_3;
				default: v[i] = '0;
			endcase
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== src/perceptron_classify_train_core.sv =====
// perceptron_classify_train_core: top level of the perceptron classify/train block
// depends on pcpt_pkg, pcpt_dot, pcpt_weights
//
//   channel  | valid      | stall      | payload
//   ---------+------------+------------+------------------------------
//   request  | req_valid  | req_stall  | req (func, target, features)
//   response | rsp_valid  | rsp_stall  | rsp (decision, flags)
//   config   | cfg_wr_en  | -          | cfg_wr_data (learning rate)
//
// one transaction per cycle unless req_stall is high; a taken request passes
// the input register, then the result register, before its result leaves.
// the weight update is written at the same edge the result is registered, so the
// next transaction already sees it; the dot product and update use the same cycle.
// reset clears the weights to zero and the learning rate to 655.
// a stalled response only holds the input stage once both registers are full.
`default_nettype none

module perceptron_classify_train_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_stall,
	input  var pcpt_pkg::req_t           req,
	output logic                         rsp_valid,
	input  wire                          rsp_stall,
	output pcpt_pkg::rsp_t               rsp,
	input  wire                          cfg_wr_en,
	input  wire  [pcpt_pkg::LR_W-1:0]    cfg_wr_data
);

	logic                        valid_s1;
	pcpt_pkg::req_t              req_s1;
	logic                        rsp_valid_q;
	pcpt_pkg::rsp_t              rsp_q;
	logic [pcpt_pkg::LR_W-1:0]   lr_q;
	logic                        adv_s1;
	logic                        take;
	logic                        decision;
	logic                        sat;
	pcpt_pkg::feat_vec_t         feats;
	pcpt_pkg::wgt_vec_t          weights;
	pcpt_pkg::upd_cmd_t          cmd;

	// learning rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= pcpt_pkg::LR_RESET;
		end else if (cfg_wr_en) begin
			lr_q <= cfg_wr_data;
		end
	end

	// handshake: stage one moves on when the result register is free or draining
	assign adv_s1    = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv_s1;
	assign take      = req_valid && !req_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
	end

	assign feats = pcpt_pkg::feat_vec(req_s1);

	// classification on the weights held before this transaction
	pcpt_dot u_dot (
		.feats    (feats),
		.weights  (weights),
		.decision (decision)
	);

	// update command for the weight bank
	always_comb begin
		cmd.commit = adv_s1;
		cmd.train  = (req_s1.func == pcpt_pkg::FUNC_TRAIN) && (decision != req_s1.target);
		cmd.load   = (req_s1.func == pcpt_pkg::FUNC_LOAD);
		cmd.target = req_s1.target;
	end

	pcpt_weights u_weights (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.learning_rate (lr_q),
		.feats         (feats),
		.weights       (weights),
		.saturated     (sat)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q.decision     <= decision;
			rsp_q.mispredicted <= cmd.train;
			rsp_q.saturated    <= sat;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// no back-pressure on the request side while the input stage is empty
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !req_stall)
		else $error("request stalled with empty input stage");

	// an item leaving stage one shows up as a valid response next cycle
	a_adv_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> rsp_valid)
		else $error("advanced item did not reach the result register");

	// clipping only happens on a training update
	a_sat_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.saturated |-> rsp.mispredicted)
		else $error("saturation flagged without a weight update");

	// a load leaves the low nibble of each weight clear (checked on weight 0)
	a_load_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && cmd.load |=> weights[0][3:0] == 4'b0000)
		else $error("loaded weight not in Q16.16 alignment");
`endif

endmodule

`default_nettype wire

// ===== src/pcpt_dot.sv =====
// pcpt_dot: parallel feature-weight products, exact sum and sign decision
// depends on pcpt_pkg
`default_nettype none

module pcpt_dot (
	input  var pcpt_pkg::feat_vec_t feats,
	input  var pcpt_pkg::wgt_vec_t  weights,
	output logic                    decision
);

	logic signed [pcpt_pkg::PROD_W-1:0] prod [pcpt_pkg::NUM_WEIGHTS];
	logic signed [pcpt_pkg::SUM_W-1:0]  sum;

	// one multiplier per lane, exact products
	always_comb begin
		for (int i = 0; i < pcpt_pkg::NUM_WEIGHTS; i++) begin
			prod[i] = feats[i] * weights[i];
		end
	end

	// exact sum, sign-extended to the full width
	always_comb begin
		sum = '0;
		for (int i = 0; i < pcpt_pkg::NUM_WEIGHTS; i++) begin
			sum = sum + pcpt_pkg::SUM_W'(prod[i]);
		end
	end

	// strictly positive sum is class +1
	assign decision = (sum > 0);

endmodule

`default_nettype wire

// ===== src/pcpt_weights.sv =====
// pcpt_weights: weight register bank with saturating training update and load
// depends on pcpt_pkg
`default_nettype none

module pcpt_weights (
	input  wire                              clk,
	input  wire                              arst_n,
	input  var pcpt_pkg::upd_cmd_t           cmd,
	input  wire  [pcpt_pkg::LR_W-1:0]        learning_rate,
	input  var pcpt_pkg::feat_vec_t          feats,
	output pcpt_pkg::wgt_vec_t               weights,
	output logic                             saturated
);

	localparam int MUL_W  = pcpt_pkg::LR_W + 1 + pcpt_pkg::FEAT_W;
	localparam int TERM_W = MUL_W + 2;
	localparam int EXT_W  = TERM_W + 1;

	localparam logic signed [EXT_W-1:0] W_MAX_X = EXT_W'(signed'({1'b0, {(pcpt_pkg::WGT_W-1){1'b1}}}));
	localparam logic signed [EXT_W-1:0] W_MIN_X = EXT_W'(signed'({1'b1, {(pcpt_pkg::WGT_W-1){1'b0}}}));

	pcpt_pkg::wgt_vec_t          weights_q;
	pcpt_pkg::wgt_vec_t          trained;
	logic signed [MUL_W-1:0]     rate_feat [pcpt_pkg::NUM_WEIGHTS];
	logic signed [TERM_W-1:0]    term      [pcpt_pkg::NUM_WEIGHTS];
	logic signed [TERM_W-1:0]    delta     [pcpt_pkg::NUM_WEIGHTS];
	logic signed [EXT_W-1:0]     wsum      [pcpt_pkg::NUM_WEIGHTS];
	logic [pcpt_pkg::NUM_WEIGHTS-1:0] clip;

	// rate * error * feature, floored back to Q16.16, added and clipped per lane
	always_comb begin
		for (int i = 0; i < pcpt_pkg::NUM_WEIGHTS; i++) begin
			rate_feat[i] = $signed({1'b0, learning_rate}) * feats[i];
			term[i]  = cmd.target ? {rate_feat[i][MUL_W-1], rate_feat[i], 1'b0}
			                      : -{rate_feat[i][MUL_W-1], rate_feat[i], 1'b0};
			delta[i] = term[i] >>> 12;
			wsum[i]  = EXT_W'(weights_q[i]) + EXT_W'(delta[i]);
			clip[i]  = 1'b0;
			if (wsum[i] > W_MAX_X) begin
				trained[i] = W_MAX_X[pcpt_pkg::WGT_W-1:0];
				clip[i]    = 1'b1;
			end else if (wsum[i] < W_MIN_X) begin
				trained[i] = W_MIN_X[pcpt_pkg::WGT_W-1:0];
				clip[i]    = 1'b1;
			end else begin
				trained[i] = wsum[i][pcpt_pkg::WGT_W-1:0];
			end
		end
	end

	assign saturated = cmd.train && (|clip);

	// weight registers: train on a misprediction, load copies features in Q16.16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcpt_pkg::NUM_WEIGHTS; i++) begin
				weights_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < pcpt_pkg::NUM_WEIGHTS; i++) begin
				if (cmd.load) begin
					weights_q[i] <= {{(pcpt_pkg::WGT_W-pcpt_pkg::FEAT_W-4){feats[i][pcpt_pkg::FEAT_W-1]}},
					                 feats[i], 4'b0000};
				end else if (cmd.train) begin
					weights_q[i] <= trained[i];
				end
			end
		end
	end

	assign weights = weights_q;

endmodule

`default_nettype wire
